>>> design/rgbc_pkg.sv
`timescale 1ns / 1ps

package rgbc_pkg;

  // Fixed field widths.
  localparam int CH_BITS       = 8;
  localparam int COEF_BITS     = 8;
  localparam int SUM_BITS      = 21;
  localparam int QUO_MAG_BITS  = 20;
  localparam int DIVISOR_BITS  = 12;
  localparam int REM_BITS      = DIVISOR_BITS + 1;
  localparam int DIV_CNT_BITS  = 5;
  localparam int ROW_BITS      = 12;
  localparam int HGT_BITS      = 13;
  localparam int WIDTH_BITS    = 11;
  localparam int OUT_COL_BITS  = 10;
  localparam int CFG_DATA_BITS = 40;
  localparam int CFG_IDX_BITS  = 3;
  localparam int TAP_IDX_BITS  = 3;
  localparam int COEF_ROWS     = 5;
  localparam int MAX_HEIGHT    = 4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ROW_0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ROW_4 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH      = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT     = 3'd7;

  // Opcodes of an input beat.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [CH_BITS-1:0] r;
    logic [CH_BITS-1:0] g;
    logic [CH_BITS-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] r;
    logic signed [SUM_BITS-1:0] g;
    logic signed [SUM_BITS-1:0] b;
  } chan_sum_t;

endpackage

>>> design/rgb_convolution_replicate_border.sv
`timescale 1ns / 1ps

// RGB image convolution with replicated borders.
// Input beats carry one pixel in raster order (opcode pixel) or a drain
// request (opcode drain). After the last pixel of a frame, send
// (KERNEL/2)*width + KERNEL/2 drain beats to flush the bottom rows.
// Each output beat carries the three filtered channels (signed quotient
// of the window sum by the divisor, truncated toward zero), the output
// row and column, and last_of_frame on the final pixel of the image.
// Frame geometry is sampled on the first pixel beat of a frame.
// Configuration writes are taken at any time but must only be made while
// the block is idle.
// A beat that yields a result first reads the window taps from the line
// store through its single read port, then lets the sum ripple along the
// cell row, and then runs the bit-serial divider.
// A finished result sits in the output register; the next input beat is
// accepted meanwhile, and work stops only if a new result is ready while
// the receiver still stalls. Reset returns to idle with no frame open.
module rgb_convolution_replicate_border #(
  parameter int KERNEL    = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   opcode,
  input  logic [rgbc_pkg::CH_BITS-1:0]           red,
  input  logic [rgbc_pkg::CH_BITS-1:0]           green,
  input  logic [rgbc_pkg::CH_BITS-1:0]           blue,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rgbc_pkg::SUM_BITS-1:0]   out_red,
  output logic signed [rgbc_pkg::SUM_BITS-1:0]   out_green,
  output logic signed [rgbc_pkg::SUM_BITS-1:0]   out_blue,
  output logic [rgbc_pkg::ROW_BITS-1:0]          out_row,
  output logic [rgbc_pkg::OUT_COL_BITS-1:0]      out_column,
  output logic                                   last_of_frame,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import rgbc_pkg::*;

  localparam int HALF        = KERNEL / 2;
  localparam int WIN         = 2 * HALF + 1;
  localparam int NTAP        = WIN * WIN;
  localparam int STORE_DEPTH = KERNEL * MAX_WIDTH + KERNEL;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(MAX_WIDTH + 1);
  localparam int TB          = CW + HGT_BITS;
  localparam int ICW         = $clog2(NTAP + 1);
  localparam int EW0         = (AW > CW) ? AW : CW;
  localparam int EW          = ((EW0 > ROW_BITS + 1) ? EW0 : ROW_BITS + 1) + 3;

  typedef enum logic [2:0] {
    S_IDLE, S_GEOM, S_EVAL, S_GATHER, S_SUM, S_DIVGO, S_DIV, S_DONE
  } state_t;

  // Configuration registers.
  logic [CFG_DATA_BITS-1:0] coef_row [COEF_ROWS];
  logic [DIVISOR_BITS-1:0]  divisor;
  logic [WIDTH_BITS-1:0]    image_width;
  logic [HGT_BITS-1:0]      image_height;

  // Control state.
  state_t                state;
  logic                  active;
  logic                  item_op;
  pixel_t                item_px;
  logic [CW-1:0]         frame_w;
  logic [HGT_BITS-1:0]   frame_h;
  logic [TB-1:0]         total;
  logic [TB-1:0]         lag;
  logic [TB-1:0]         pixels_in;
  logic [TB-1:0]         items_seen;
  logic [TB-1:0]         out_count;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         out_addr;
  logic [ROW_BITS-1:0]   output_row;
  logic [CW-1:0]         output_column;
  logic [ROW_BITS-1:0]   rr;
  logic signed [EW-1:0]  roff;
  logic [TAP_IDX_BITS-1:0] tap_i;
  logic [TAP_IDX_BITS-1:0] tap_j;
  logic [ICW-1:0]        issue_cnt;
  logic                  rd_pending;
  logic [ICW-1:0]        sum_cnt;

  // Datapath wires.
  logic                  wr_en;
  logic [AW-1:0]         rd_addr;
  pixel_t                rd_data;
  pixel_t                tap_chain  [NTAP+1];
  chan_sum_t             psum_chain [NTAP+1];
  logic                  div_start;
  logic                  done_r, done_g, done_b;
  logic signed [SUM_BITS-1:0] quo_r, quo_g, quo_b;
  logic                  is_last;

  logic signed [EW-1:0]  w_ext;
  logic signed [EW-1:0]  col_ext;
  logic signed [EW-1:0]  c_raw;
  logic signed [EW-1:0]  c_cl;
  logic signed [EW-1:0]  coff;
  logic signed [EW-1:0]  a_sum;
  logic signed [EW-1:0]  a_wrap;
  logic signed [EW-1:0]  t_next;
  logic                  row_adv;
  logic [ROW_BITS-1:0]   diff;
  logic [ROW_BITS-1:0]   rr0;
  logic signed [EW-1:0]  roff0;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_ROWS; i++) begin
        coef_row[i] <= '0;
      end
      divisor      <= DIVISOR_BITS'(1);
      image_width  <= WIDTH_BITS'(1024);
      image_height <= HGT_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIVISOR: divisor      <= cfg_data[DIVISOR_BITS-1:0];
        REG_WIDTH:   image_width  <= cfg_data[WIDTH_BITS-1:0];
        REG_HEIGHT:  image_height <= cfg_data[HGT_BITS-1:0];
        default: begin
          if (cfg_index <= REG_COEF_ROW_4) begin
            coef_row[cfg_index] <= cfg_data;
          end
        end
      endcase
    end
  end

  // Tap address: output pixel address plus row and column offsets,
  // with clamping to the image edge and one wrap around the store.
  always_comb begin
    w_ext   = $signed(EW'(frame_w));
    col_ext = $signed(EW'(output_column));
    c_raw   = col_ext + $signed(EW'(tap_j)) - $signed(EW'(HALF));
    if (c_raw < 0) begin
      c_cl = '0;
    end else if (c_raw > w_ext - $signed(EW'(1))) begin
      c_cl = w_ext - $signed(EW'(1));
    end else begin
      c_cl = c_raw;
    end
    coff  = c_cl - col_ext;
    a_sum = $signed(EW'(out_addr)) + roff + coff;
    if (a_sum < 0) begin
      a_wrap = a_sum + $signed(EW'(STORE_DEPTH));
    end else if (a_sum >= $signed(EW'(STORE_DEPTH))) begin
      a_wrap = a_sum - $signed(EW'(STORE_DEPTH));
    end else begin
      a_wrap = a_sum;
    end
    rd_addr = a_wrap[AW-1:0];

    // The clamped row moves down only inside the image.
    t_next  = $signed(EW'(output_row)) + $signed(EW'(tap_i)) + $signed(EW'(1))
              - $signed(EW'(HALF));
    row_adv = (t_next > 0) && ({1'b0, rr} < frame_h - HGT_BITS'(1));

    // First row of the window and its offset from the output row.
    diff  = (output_row < ROW_BITS'(HALF)) ? output_row : ROW_BITS'(HALF);
    rr0   = output_row - diff;
    roff0 = -($signed(EW'(diff)) * w_ext);
  end

  assign wr_en     = (state == S_EVAL) && (pixels_in < total) && (item_op == OP_PIXEL);
  assign div_start = (state == S_DIVGO);
  assign is_last   = (out_count == total - TB'(1));

  // Line store.
  rgbc_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item_px),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Window cells: taps shift in from the store, sums ripple to the end.
  assign tap_chain[0]  = rd_data;
  assign psum_chain[0] = '0;

  for (genvar j = 0; j < NTAP; j++) begin : g_cell
    localparam int T  = NTAP - 1 - j;
    localparam int CR = 2 - HALF + T / WIN;
    localparam int CC = 2 - HALF + T % WIN;
    rgbc_cell u_cell (
      .clk      (clk),
      .shift    (rd_pending),
      .coef     ($signed(coef_row[CR][COEF_BITS*CC +: COEF_BITS])),
      .tap_in   (tap_chain[j]),
      .tap_out  (tap_chain[j+1]),
      .psum_in  (psum_chain[j]),
      .psum_out (psum_chain[j+1])
    );
  end

  // Normalizing dividers, one per channel.
  rgbc_div u_div_r (
    .clk (clk), .rst (rst), .start (div_start), .dividend (psum_chain[NTAP].r),
    .divisor (divisor), .quotient (quo_r), .done (done_r)
  );
  rgbc_div u_div_g (
    .clk (clk), .rst (rst), .start (div_start), .dividend (psum_chain[NTAP].g),
    .divisor (divisor), .quotient (quo_g), .done (done_g)
  );
  rgbc_div u_div_b (
    .clk (clk), .rst (rst), .start (div_start), .dividend (psum_chain[NTAP].b),
    .divisor (divisor), .quotient (quo_b), .done (done_b)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active        <= 1'b0;
      out_valid     <= 1'b0;
      pixels_in     <= '0;
      items_seen    <= '0;
      out_count     <= '0;
      wr_addr       <= '0;
      out_addr      <= '0;
      output_row    <= '0;
      output_column <= '0;
      rd_pending    <= 1'b0;
      issue_cnt     <= '0;
      sum_cnt       <= '0;
      tap_i         <= '0;
      tap_j         <= '0;
    end else begin
      // A result leaving while a new one is loaded is handled in S_DONE.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_op <= opcode;
            item_px <= '{r: red, g: green, b: blue};
            if (!active) begin
              if (opcode == OP_PIXEL) begin
                if (image_width == '0) begin
                  frame_w <= CW'(1);
                end else if (32'(image_width) > MAX_WIDTH) begin
                  frame_w <= CW'(MAX_WIDTH);
                end else begin
                  frame_w <= CW'(image_width);
                end
                if (image_height == '0) begin
                  frame_h <= HGT_BITS'(1);
                end else if (32'(image_height) > MAX_HEIGHT) begin
                  frame_h <= HGT_BITS'(MAX_HEIGHT);
                end else begin
                  frame_h <= image_height;
                end
                pixels_in     <= '0;
                items_seen    <= '0;
                out_count     <= '0;
                wr_addr       <= '0;
                out_addr      <= '0;
                output_row    <= '0;
                output_column <= '0;
                active        <= 1'b1;
                state         <= S_GEOM;
              end
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_GEOM: begin
          total <= TB'(frame_w) * TB'(frame_h);
          lag   <= TB'(HALF) * TB'(frame_w) + TB'(HALF);
          state <= S_EVAL;
        end
        S_EVAL: begin
          if ((pixels_in < total) && (item_op == OP_DRAIN)) begin
            // A drain beat before the frame is complete is dropped.
            state <= S_IDLE;
          end else begin
            if (pixels_in < total) begin
              pixels_in <= pixels_in + TB'(1);
              wr_addr   <= (wr_addr == AW'(STORE_DEPTH - 1)) ? '0 : wr_addr + AW'(1);
            end
            items_seen <= items_seen + TB'(1);
            if (items_seen < lag) begin
              state <= S_IDLE;
            end else begin
              state      <= S_GATHER;
              tap_i      <= '0;
              tap_j      <= '0;
              issue_cnt  <= '0;
              rd_pending <= 1'b0;
              rr         <= rr0;
              roff       <= roff0;
            end
          end
        end
        S_GATHER: begin
          rd_pending <= (issue_cnt < ICW'(NTAP));
          if (issue_cnt < ICW'(NTAP)) begin
            issue_cnt  <= issue_cnt + ICW'(1);
            if (tap_j == TAP_IDX_BITS'(WIN - 1)) begin
              tap_j <= '0;
              tap_i <= tap_i + TAP_IDX_BITS'(1);
              if (row_adv) begin
                rr   <= rr + ROW_BITS'(1);
                roff <= roff + w_ext;
              end
            end else begin
              tap_j <= tap_j + TAP_IDX_BITS'(1);
            end
          end else begin
            state   <= S_SUM;
            sum_cnt <= '0;
          end
        end
        S_SUM: begin
          if (sum_cnt == ICW'(NTAP - 1)) begin
            state <= S_DIVGO;
          end else begin
            sum_cnt <= sum_cnt + ICW'(1);
          end
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (done_r && done_g && done_b) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            out_red       <= quo_r;
            out_green     <= quo_g;
            out_blue      <= quo_b;
            out_row       <= output_row;
            out_column    <= OUT_COL_BITS'(output_column);
            last_of_frame <= is_last;
            state         <= S_IDLE;
            if (is_last) begin
              active        <= 1'b0;
              pixels_in     <= '0;
              items_seen    <= '0;
              out_count     <= '0;
              wr_addr       <= '0;
              out_addr      <= '0;
              output_row    <= '0;
              output_column <= '0;
            end else begin
              out_count <= out_count + TB'(1);
              out_addr  <= (out_addr == AW'(STORE_DEPTH - 1)) ? '0 : out_addr + AW'(1);
              if (output_column == frame_w - CW'(1)) begin
                output_column <= '0;
                output_row    <= output_row + ROW_BITS'(1);
              end else begin
                output_column <= output_column + CW'(1);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Tap reads stay inside the line store.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_GATHER) |-> (32'(rd_addr) < STORE_DEPTH))
    else $error("tap address outside line store");

  // The write pointer wraps at the store depth.
  assert property (@(posedge clk) disable iff (rst)
    32'(wr_addr) < STORE_DEPTH)
    else $error("write pointer outside line store");

  // No result is produced past the end of the frame.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (out_count < total))
    else $error("output count beyond frame size");

  // A finished result always lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (!out_valid || out_ready)) |=> out_valid)
    else $error("result lost at output register");

endmodule

>>> design/rgbc_ram.sv
`timescale 1ns / 1ps

module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 5125
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/rgbc_cell.sv
`timescale 1ns / 1ps

module rgbc_cell (
  input  logic                                clk,
  input  logic                                shift,
  input  logic signed [rgbc_pkg::COEF_BITS-1:0] coef,
  input  rgbc_pkg::pixel_t                    tap_in,
  output rgbc_pkg::pixel_t                    tap_out,
  input  rgbc_pkg::chan_sum_t                 psum_in,
  output rgbc_pkg::chan_sum_t                 psum_out
);
  import rgbc_pkg::*;

  localparam int PROD_BITS = COEF_BITS + CH_BITS + 1;

  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [PROD_BITS-1:0] prod_g;
  logic signed [PROD_BITS-1:0] prod_b;

  // Each cell weights its own tap by its fixed kernel position.
  assign prod_r = coef * $signed({1'b0, tap_out.r});
  assign prod_g = coef * $signed({1'b0, tap_out.g});
  assign prod_b = coef * $signed({1'b0, tap_out.b});

  // The tap moves down the row while gathering; the partial sum
  // ripples one cell per cycle.
  always_ff @(posedge clk) begin
    if (shift) begin
      tap_out <= tap_in;
    end
    psum_out.r <= psum_in.r + SUM_BITS'(prod_r);
    psum_out.g <= psum_in.g + SUM_BITS'(prod_g);
    psum_out.b <= psum_in.b + SUM_BITS'(prod_b);
  end

endmodule

>>> design/rgbc_div.sv
`timescale 1ns / 1ps

module rgbc_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [rgbc_pkg::SUM_BITS-1:0]   dividend,
  input  logic [rgbc_pkg::DIVISOR_BITS-1:0]      divisor,
  output logic signed [rgbc_pkg::SUM_BITS-1:0]   quotient,
  output logic                                   done
);
  import rgbc_pkg::*;

  logic                      busy;
  logic [DIV_CNT_BITS-1:0]   cnt;
  logic [REM_BITS-1:0]       rem;
  logic [QUO_MAG_BITS-1:0]   mag;
  logic [DIVISOR_BITS-1:0]   den;
  logic                      neg;
  logic signed [SUM_BITS-1:0] neg_dividend;
  logic [REM_BITS-1:0]       trial;

  assign neg_dividend = -dividend;
  assign trial = {rem[REM_BITS-2:0], mag[QUO_MAG_BITS-1]};

  // Quotient truncates toward zero: divide magnitudes, then restore sign.
  assign quotient = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        neg  <= dividend[SUM_BITS-1];
        mag  <= dividend[SUM_BITS-1] ? neg_dividend[QUO_MAG_BITS-1:0]
                                     : dividend[QUO_MAG_BITS-1:0];
        den  <= (divisor == '0) ? DIVISOR_BITS'(1) : divisor;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          mag <= {mag[QUO_MAG_BITS-2:0], 1'b1};
        end else begin
          rem <= trial;
          mag <= {mag[QUO_MAG_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(QUO_MAG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> tb/conv_checker.sv
`timescale 1ns / 1ps

module conv_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 opcode,
  input  logic [rgbc_pkg::CH_BITS-1:0]         red,
  input  logic [rgbc_pkg::CH_BITS-1:0]         green,
  input  logic [rgbc_pkg::CH_BITS-1:0]         blue,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [rgbc_pkg::SUM_BITS-1:0] out_red,
  input  logic signed [rgbc_pkg::SUM_BITS-1:0] out_green,
  input  logic signed [rgbc_pkg::SUM_BITS-1:0] out_blue,
  input  logic [rgbc_pkg::ROW_BITS-1:0]        out_row,
  input  logic [rgbc_pkg::OUT_COL_BITS-1:0]    out_column,
  input  logic                                 last_of_frame,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   results_seen
);
  import rgbc_pkg::*;

  localparam int MAXW  = 1024;
  localparam int DEPTH = 5 * MAXW + 5;

  typedef struct {
    logic signed [SUM_BITS-1:0] r;
    logic signed [SUM_BITS-1:0] g;
    logic signed [SUM_BITS-1:0] b;
    logic [ROW_BITS-1:0]        row;
    logic [OUT_COL_BITS-1:0]    col;
    logic                       last;
  } filtered_pixel_t;

  filtered_pixel_t expected_pixels[$];

  // Shadow of the configuration registers.
  logic [CFG_DATA_BITS-1:0] coef_rows [0:4];
  logic [DIVISOR_BITS-1:0]  divisor_reg;
  logic [WIDTH_BITS-1:0]    width_reg;
  logic [HGT_BITS-1:0]      height_reg;

  // Frame state of the filter.
  pixel_t pixel_ring [0:DEPTH-1];
  int     frame_w, frame_h, items_seen, pixels_in, row_now, col_now;
  bit     frame_open;

  task automatic reset_filter();
    for (int i = 0; i < 5; i++) coef_rows[i] = '0;
    divisor_reg = DIVISOR_BITS'(1);
    width_reg   = WIDTH_BITS'(1024);
    height_reg  = HGT_BITS'(1);
    frame_open  = 0;
    items_seen  = 0;
    pixels_in   = 0;
    row_now     = 0;
    col_now     = 0;
    expected_pixels.delete();
  endtask

  // Advances the filter by one input beat and queues the pixel it produces.
  task automatic filter_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int total, lag, rr, cc, k, div;
    longint sr, sg, sb;
    pixel_t px;
    filtered_pixel_t res;
    if (!frame_open) begin
      if (op == OP_DRAIN) return;
      frame_w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
      frame_h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      row_now = 0;
      col_now = 0;
      items_seen = 0;
      pixels_in = 0;
      frame_open = 1;
    end
    total = frame_w * frame_h;
    if (pixels_in < total) begin
      if (op == OP_DRAIN) return;
      pixel_ring[pixels_in % DEPTH] = '{r: r, g: g, b: b};
      pixels_in++;
    end
    lag = 2 * frame_w + 2;
    items_seen++;
    if (items_seen - 1 < lag) return;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int dy = -2; dy <= 2; dy++) begin
      rr = row_now + dy;
      rr = (rr < 0) ? 0 : ((rr > frame_h - 1) ? frame_h - 1 : rr);
      for (int dx = -2; dx <= 2; dx++) begin
        cc = col_now + dx;
        cc = (cc < 0) ? 0 : ((cc > frame_w - 1) ? frame_w - 1 : cc);
        px = pixel_ring[(rr * frame_w + cc) % DEPTH];
        k = int'($signed(coef_rows[2 + dy][8 * (2 + dx) +: 8]));
        sr += longint'(k * int'(px.r));
        sg += longint'(k * int'(px.g));
        sb += longint'(k * int'(px.b));
      end
    end
    div = (divisor_reg == 0) ? 1 : int'(divisor_reg);
    res.r = SUM_BITS'(sr / div);
    res.g = SUM_BITS'(sg / div);
    res.b = SUM_BITS'(sb / div);
    res.row = ROW_BITS'(row_now);
    res.col = OUT_COL_BITS'(col_now);
    res.last = (row_now * frame_w + col_now == total - 1);
    expected_pixels.push_back(res);
    if (++col_now >= frame_w) begin
      col_now = 0;
      row_now++;
    end
    if (res.last) frame_open = 0;
  endtask

  // Compares one output beat with the oldest expected pixel.
  task automatic compare_pixel();
    filtered_pixel_t e;
    if (expected_pixels.size() == 0) begin
      $error("Output beat with no expected pixel: row %0d column %0d", out_row, out_column);
      fail_count++;
      return;
    end
    e = expected_pixels.pop_front();
    results_seen++;
    if (out_red !== e.r) begin
      $error("out_red: expected %0d, got %0d", e.r, out_red);
      fail_count++;
    end
    if (out_green !== e.g) begin
      $error("out_green: expected %0d, got %0d", e.g, out_green);
      fail_count++;
    end
    if (out_blue !== e.b) begin
      $error("out_blue: expected %0d, got %0d", e.b, out_blue);
      fail_count++;
    end
    if (out_row !== e.row) begin
      $error("out_row: expected %0d, got %0d", e.row, out_row);
      fail_count++;
    end
    if (out_column !== e.col) begin
      $error("out_column: expected %0d, got %0d", e.col, out_column);
      fail_count++;
    end
    if (last_of_frame !== e.last) begin
      $error("last_of_frame: expected %0d, got %0d", e.last, last_of_frame);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    reset_filter();
  end

  // Checks output beats and tracks config writes and input beats.
  always @(posedge clk) begin
    if (rst) begin
      reset_filter();
    end else begin
      if (out_valid && out_ready) compare_pixel();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIVISOR: divisor_reg = cfg_data[DIVISOR_BITS-1:0];
          REG_WIDTH:   width_reg = cfg_data[WIDTH_BITS-1:0];
          REG_HEIGHT:  height_reg = cfg_data[HGT_BITS-1:0];
          default:     coef_rows[cfg_index] = cfg_data;
        endcase
      end
      if (in_valid && in_ready) filter_beat(opcode, red, green, blue);
    end
    pending = expected_pixels.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rgbc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic opcode = OP_PIXEL;
  logic [CH_BITS-1:0] red = 0, green = 0, blue = 0;
  logic out_valid, out_ready = 0;
  logic signed [SUM_BITS-1:0] out_red, out_green, out_blue;
  logic [ROW_BITS-1:0] out_row;
  logic [OUT_COL_BITS-1:0] out_column;
  logic last_of_frame;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_COEF_ROW_0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int fail_count, pending, results_seen;
  int beats_sent, random_beats, frames_run;
  bit calm = 0;
  bit hold_request = 0;
  longint cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  rgb_convolution_replicate_border uut (.*);

  conv_checker checker_i (.*);

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Offers one input beat; valid stays high into the next beat unless idling.
  task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!calm && $urandom_range(99) < 35) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Waits until every expected pixel has come out and the block has settled.
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] chan_value(bit extremes);
    if (extremes) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // Kernel row: full 5x5, centered 3x3, or center tap only.
  function automatic logic [39:0] kernel_row(int kind, int row);
    logic [39:0] v;
    v = 40'({$urandom, $urandom});
    if (kind == 1) v = (row >= 1 && row <= 3) ? (v & 40'h00_FFFF_FF00) : '0;
    if (kind == 2) v = (row == 2) ? (v & 40'h00_00FF_0000) : '0;
    return v;
  endfunction

  task automatic load_kernel(int kind, logic [11:0] div);
    for (int i = 0; i < 5; i++) begin
      write_reg(REG_COEF_ROW_0 + CFG_IDX_BITS'(i), kernel_row(kind, i));
    end
    write_reg(REG_DIVISOR, CFG_DATA_BITS'(div));
  endtask

  // Sends one frame of pixels, its drain beats and some ignored noise.
  task automatic run_frame(int w, int h, bit extremes, bit noisy);
    int cw, ch, lag;
    cw = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    ch = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
    lag = 2 * cw + 2;
    write_reg(REG_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_HEIGHT, CFG_DATA_BITS'(h));
    if (noisy) send_beat(OP_DRAIN, chan_value(0), chan_value(0), chan_value(0));
    for (int i = 0; i < cw * ch; i++) begin
      if (noisy && i > 0 && $urandom_range(99) < 8) send_beat(OP_DRAIN, 8'h5A, 8'hA5, 8'h3C);
      send_beat(OP_PIXEL, chan_value(extremes), chan_value(extremes), chan_value(extremes));
    end
    for (int i = 0; i < lag; i++) begin
      // A surplus pixel flushes just like a drain beat.
      if (noisy && $urandom_range(99) < 20)
        send_beat(OP_PIXEL, chan_value(0), chan_value(0), chan_value(0));
      else
        send_beat(OP_DRAIN, chan_value(0), chan_value(0), chan_value(0));
    end
    frames_run++;
    settle();
  endtask

  initial begin
    int w, h, kind, start;
    beats_sent = 0;
    frames_run = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Drain beat with no frame open is ignored.
    send_beat(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // Identity kernel on a tiny frame of extreme values, with noise.
    write_reg(REG_COEF_ROW_0 + CFG_IDX_BITS'(2), 40'h00_0001_0000);
    run_frame(3, 2, 1, 1);

    // Most negative taps with zero divisor, then most positive with the largest.
    load_kernel(0, 12'd0);
    for (int i = 0; i < 5; i++) write_reg(REG_COEF_ROW_0 + CFG_IDX_BITS'(i), 40'h80_8080_8080);
    run_frame(1, 1, 1, 0);
    for (int i = 0; i < 5; i++) write_reg(REG_COEF_ROW_0 + CFG_IDX_BITS'(i), 40'h7F_7F7F_7F7F);
    write_reg(REG_DIVISOR, 40'd4095);
    run_frame(0, 0, 1, 0);
    write_reg(REG_DIVISOR, 40'd1);
    run_frame(2, 3, 1, 0);

    // Wider frame with a centered 3x3 kernel.
    load_kernel(1, 12'd7);
    run_frame(40, 2, 0, 0);

    // Random frames, mostly small, with a calm stretch and one long hold-off.
    start = beats_sent;
    while (beats_sent - start < 350) begin
      calm = (frames_run % 12 >= 8);
      if (frames_run == 10) hold_request = 1;
      kind = $urandom_range(2);
      load_kernel(kind, ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(4095)));
      w = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      run_frame(w, h, $urandom_range(3) == 0, 1'($urandom_range(1)));
    end
    random_beats = beats_sent - start;
    calm = 0;
    settle();

    $display("Run covered %0d frames, %0d input beats (%0d random), %0d output pixels checked.",
             frames_run, beats_sent, random_beats, results_seen);
    $display("Included widths 0 to 40, signed extreme kernels, zero divisor and stray drains.");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
